// ----- hw/rtl/dss_pkg.sv -----
// Package for the dual stack shared store: sizes, opcode and status codes,
// and the item and command types used by the front, back and top level.
// No dependencies.
package dss_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int USED_W      = CNT_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] OP_PUSH_A    = 3'd0;
    localparam logic [2:0] OP_PUSH_B    = 3'd1;
    localparam logic [2:0] OP_PUSH_BOTH = 3'd2;
    localparam logic [2:0] OP_POP_A     = 3'd3;
    localparam logic [2:0] OP_POP_B     = 3'd4;
    localparam logic [2:0] OP_POP_BOTH  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [1:0] KIND_NOP  = 2'd0;
    localparam logic [1:0] KIND_PUSH = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    typedef struct packed {
        logic        [2:0]        opcode;
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
    } in_item_t;

    typedef struct packed {
        logic        [1:0]        status;
        logic signed [DATA_W-1:0] popped_a;
        logic signed [DATA_W-1:0] popped_b;
        logic signed [DATA_W-1:0] top_a;
        logic                     empty_a;
        logic signed [DATA_W-1:0] top_b;
        logic                     empty_b;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              do_a;
        logic              do_b;
        logic [DATA_W-1:0] value_a;
        logic [DATA_W-1:0] value_b;
    } cmd_t;

endpackage

// ----- hw/rtl/dss_front.sv -----
// Front end: accepts input items, decodes the opcode into a command and
// holds commands in a short queue for the back end. Depends on dss_pkg.
module dss_front
    import dss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t request,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              decoded;
    logic              wr_en;
    logic              rd_en;

    always_comb
    begin
        decoded         = '0;
        decoded.value_a = request.value_a;
        decoded.value_b = request.value_b;
        case (request.opcode)
            OP_PUSH_A:
            begin
                decoded.kind = KIND_PUSH;
                decoded.do_a = 1'b1;
            end
            OP_PUSH_B:
            begin
                decoded.kind = KIND_PUSH;
                decoded.do_b = 1'b1;
            end
            OP_PUSH_BOTH:
            begin
                decoded.kind = KIND_PUSH;
                decoded.do_a = 1'b1;
                decoded.do_b = 1'b1;
            end
            OP_POP_A:
            begin
                decoded.kind = KIND_POP;
                decoded.do_a = 1'b1;
            end
            OP_POP_B:
            begin
                decoded.kind = KIND_POP;
                decoded.do_b = 1'b1;
            end
            OP_POP_BOTH:
            begin
                decoded.kind = KIND_POP;
                decoded.do_a = 1'b1;
                decoded.do_b = 1'b1;
            end
            default:
            begin
                decoded.kind = KIND_NOP;
            end
        endcase
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ----- hw/rtl/dss_back.sv -----
// Back end: executes commands against the shared store and the two stack
// counts, caches each stack's top and holds the finished result item.
// Depends on dss_pkg.
module dss_back
    import dss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_take,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WR_B = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_a_reg;
    logic [CNT_W-1:0]  cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg;
    logic [CNT_W-1:0]  cnt_b_next;
    logic [DATA_W-1:0] top_a_reg;
    logic [DATA_W-1:0] top_a_next;
    logic [DATA_W-1:0] top_b_reg;
    logic [DATA_W-1:0] top_b_next;
    logic [DATA_W-1:0] pa_reg;
    logic [DATA_W-1:0] pa_next;
    logic [DATA_W-1:0] pb_reg;
    logic [DATA_W-1:0] pb_next;
    logic              pop_a_reg;
    logic              pop_a_next;
    logic              pop_b_reg;
    logic              pop_b_next;
    logic [DATA_W-1:0] hold_b_reg;
    logic [DATA_W-1:0] hold_b_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         result_reg;
    out_item_t         result_next;

    logic              out_free;
    logic              emit;
    logic [1:0]        emit_status;
    logic [DATA_W-1:0] emit_pa;
    logic [DATA_W-1:0] emit_pb;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [USED_W-1:0] used;
    logic [USED_W-1:0] need;
    logic              overflow;
    logic              underflow;
    logic [CNT_W-1:0]  b_push_addr;
    logic [CNT_W-1:0]  a_rd_addr;
    logic [USED_W-1:0] b_rd_addr;

    assign out_free    = !out_valid_reg || pop;
    assign used        = USED_W'(cnt_a_reg) + USED_W'(cnt_b_reg);
    assign need        = USED_W'(cmd.do_a) + USED_W'(cmd.do_b);
    assign overflow    = (used + need) > USED_W'(CAPACITY);
    assign underflow   = (cmd.do_a && cnt_a_reg == '0) || (cmd.do_b && cnt_b_reg == '0);
    assign b_push_addr = CNT_W'(CAPACITY - 1) - cnt_b_reg;
    assign a_rd_addr   = cnt_a_reg - CNT_W'(2);
    assign b_rd_addr   = USED_W'(CAPACITY + 1) - USED_W'(cnt_b_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        top_a_next  = top_a_reg;
        top_b_next  = top_b_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        pop_a_next  = pop_a_reg;
        pop_b_next  = pop_b_reg;
        hold_b_next = hold_b_reg;
        cmd_take    = 1'b0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_pa     = '0;
        emit_pb     = '0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        KIND_PUSH:
                        begin
                            if (overflow)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_OVERFLOW;
                            end
                            else if (cmd.do_a)
                            begin
                                we         = 1'b1;
                                waddr      = cnt_a_reg[IDX_W-1:0];
                                wdata      = cmd.value_a;
                                cnt_a_next = cnt_a_reg + 1'b1;
                                top_a_next = cmd.value_a;
                                if (cmd.do_b)
                                begin
                                    hold_b_next = cmd.value_b;
                                    state_next  = S_WR_B;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = b_push_addr[IDX_W-1:0];
                                wdata      = cmd.value_b;
                                cnt_b_next = cnt_b_reg + 1'b1;
                                top_b_next = cmd.value_b;
                                emit       = 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (underflow)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                re         = 1'b1;
                                pop_a_next = cmd.do_a;
                                pop_b_next = cmd.do_b;
                                pa_next    = cmd.do_a ? top_a_reg : '0;
                                pb_next    = cmd.do_b ? top_b_reg : '0;
                                if (cmd.do_a)
                                begin
                                    cnt_a_next = cnt_a_reg - 1'b1;
                                end
                                if (cmd.do_b)
                                begin
                                    cnt_b_next = cnt_b_reg - 1'b1;
                                end
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_WR_B:
            begin
                we         = 1'b1;
                waddr      = b_push_addr[IDX_W-1:0];
                wdata      = hold_b_reg;
                cnt_b_next = cnt_b_reg + 1'b1;
                top_b_next = hold_b_reg;
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                if (pop_a_reg)
                begin
                    top_a_next = rd_a_reg;
                end
                if (pop_b_reg)
                begin
                    top_b_next = rd_b_reg;
                end
                emit       = 1'b1;
                emit_pa    = pa_reg;
                emit_pb    = pb_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next          = result_reg;
        out_valid_next       = out_valid_reg && !pop;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            result_next.status   = emit_status;
            result_next.popped_a = emit_pa;
            result_next.popped_b = emit_pb;
            result_next.empty_a  = (cnt_a_next == '0);
            result_next.top_a    = (cnt_a_next == '0) ? '1 : top_a_next;
            result_next.empty_b  = (cnt_b_next == '0);
            result_next.top_b    = (cnt_b_next == '0) ? '1 : top_b_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_a_reg  <= top_a_next;
        top_b_reg  <= top_b_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pop_a_reg  <= pop_a_next;
        pop_b_reg  <= pop_b_next;
        hold_b_reg <= hold_b_next;
        result_reg <= result_next;
    end

    // store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[a_rd_addr[IDX_W-1:0]];
            rd_b_reg <= mem[b_rd_addr[IDX_W-1:0]];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (USED_W'(cnt_a_reg) + USED_W'(cnt_b_reg)) <= USED_W'(CAPACITY))
        else $error("stack counts exceed store capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || pop))
        else $error("result written over an item not yet taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_B || state_reg == S_RD) |=> (state_reg == S_IDLE))
        else $error("second step of a command did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd_take)
        else $error("command taken while another is in progress");

endmodule

// ----- hw/rtl/dual_stack_shared_store.sv -----
// Top level of the dual stack shared store: front end decode queue and back
// end executor. Depends on dss_pkg, dss_front and dss_back.
//
// Two LIFO stacks share a store of CAPACITY 32-bit entries: stack A grows up
// from entry 0, stack B grows down from the top entry. Items are accepted
// into a two-entry command queue, so up to two items may wait while a result
// sits unread. The executor takes one command at a time: a rejected push or
// pop, an unused opcode and a single push finish in the idle state; a push to
// both stacks writes stack B in the S_WR_B state, as the store has one write
// port; a pop loads the new top in the S_RD state, as it is fetched through
// the store's registered read ports. A result reports status, the popped
// values (zero when none) and each stack's top after the step, all ones with
// the empty flag set when the stack holds nothing. Entries never written may
// be read but are never reported, so the store needs no clearing after reset.
module dual_stack_shared_store
    import dss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  request,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    dss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    dss_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for dual_stack_shared_store: directed and random push/pop traffic
// checked item by item against a behavioural model of the two shared stacks.
// Depends on dss_pkg and the dual_stack_shared_store RTL.
module tb_top;
    import dss_pkg::*;

    localparam logic [2:0] OP_SPARE_6  = 3'd6;
    localparam logic [2:0] OP_SPARE_7  = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 8;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    logic      full;
    logic      empty;
    in_item_t  request = '0;
    out_item_t result;

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int failures      = 0;
    int cycle_count   = 0;

    // model state
    logic [DATA_W-1:0] shared_mem [CAPACITY];
    logic [CNT_W-1:0]  depth_a = '0;
    logic [CNT_W-1:0]  depth_b = '0;
    out_item_t         pending_results [$];

    dual_stack_shared_store i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** dual_stack_shared_store: FAILED **");
            $finish;
        end
    end

    function automatic out_item_t stack_step(in_item_t it);
        out_item_t r;
        logic      want_a;
        logic      want_b;
        int        spare;
        r     = '0;
        spare = CAPACITY - int'(depth_a) - int'(depth_b);
        r.status = ST_OK;
        case (it.opcode)
            OP_PUSH_A, OP_PUSH_B, OP_PUSH_BOTH:
            begin
                want_a = (it.opcode != OP_PUSH_B);
                want_b = (it.opcode != OP_PUSH_A);
                if (spare < int'(want_a) + int'(want_b))
                    r.status = ST_OVERFLOW;
                else
                begin
                    if (want_a)
                    begin
                        shared_mem[depth_a] = it.value_a;
                        depth_a++;
                    end
                    if (want_b)
                    begin
                        depth_b++;
                        shared_mem[CAPACITY - int'(depth_b)] = it.value_b;
                    end
                end
            end
            OP_POP_A, OP_POP_B, OP_POP_BOTH:
            begin
                want_a = (it.opcode != OP_POP_B);
                want_b = (it.opcode != OP_POP_A);
                if ((want_a && depth_a == 0) || (want_b && depth_b == 0))
                    r.status = ST_UNDERFLOW;
                else
                begin
                    if (want_a)
                    begin
                        r.popped_a = shared_mem[depth_a - 1];
                        depth_a--;
                    end
                    if (want_b)
                    begin
                        r.popped_b = shared_mem[CAPACITY - int'(depth_b)];
                        depth_b--;
                    end
                end
            end
            default:
                r.status = ST_OK;
        endcase
        r.empty_a = (depth_a == 0);
        r.empty_b = (depth_b == 0);
        r.top_a   = r.empty_a ? '1 : shared_mem[depth_a - 1];
        r.top_b   = r.empty_b ? '1 : shared_mem[CAPACITY - int'(depth_b)];
        return r;
    endfunction

    task automatic send_item(input logic [2:0] opcode, input logic [DATA_W-1:0] va,
                             input logic [DATA_W-1:0] vb);
        in_item_t it;
        it.opcode  = opcode;
        it.value_a = va;
        it.value_b = vb;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(stack_step(it));
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            $error("result with no item outstanding: %p", got);
            failures++;
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("popped_a", want.popped_a, got.popped_a);
            compare_field("popped_b", want.popped_b, got.popped_b);
            compare_field("top_a", want.top_a, got.top_a);
            compare_field("empty_a", want.empty_a, got.empty_a);
            compare_field("top_b", want.top_b, got.top_b);
            compare_field("empty_b", want.empty_b, got.empty_b);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_result(result);
            pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_pops();
        send_item(OP_POP_A, $urandom, $urandom);
        send_item(OP_POP_B, $urandom, $urandom);
        send_item(OP_POP_BOTH, $urandom, $urandom);
    endtask

    // stored all ones must be told from an empty stack by the flags
    task automatic test_extreme_values();
        send_item(OP_PUSH_A, 32'h7fff_ffff, $urandom);
        send_item(OP_PUSH_B, $urandom, 32'h8000_0000);
        send_item(OP_PUSH_A, '1, $urandom);
        send_item(OP_PUSH_B, $urandom, '1);
        send_item(OP_POP_BOTH, $urandom, $urandom);
        send_item(OP_POP_A, $urandom, $urandom);
        send_item(OP_POP_BOTH, $urandom, $urandom);
        send_item(OP_POP_B, $urandom, $urandom);
    endtask

    task automatic test_unused_opcodes();
        send_item(OP_SPARE_6, '1, '1);
        send_item(OP_SPARE_7, $urandom, $urandom);
    endtask

    task automatic test_fill_to_overflow();
        repeat (7)
            send_item(OP_PUSH_BOTH, $urandom, $urandom);
        send_item(OP_PUSH_A, $urandom, $urandom);
        send_item(OP_PUSH_BOTH, $urandom, $urandom);
        send_item(OP_PUSH_B, $urandom, $urandom);
        send_item(OP_PUSH_A, $urandom, $urandom);
        send_item(OP_PUSH_BOTH, $urandom, $urandom);
        send_item(OP_POP_BOTH, $urandom, $urandom);
    endtask

    // swings between filling and draining so both bounds are hit often
    task automatic test_random_traffic(input int send_pct, input int take_pct,
                                       input int count);
        logic       filling;
        logic [2:0] opcode;
        int         roll;
        filling       = 1'b1;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        repeat (count)
        begin
            if (int'(depth_a) + int'(depth_b) == CAPACITY)
                filling = 1'b0;
            else if (depth_a == 0 && depth_b == 0)
                filling = 1'b1;
            else if ($urandom_range(19) == 0)
                filling = ~filling;
            roll = $urandom_range(99);
            if (roll < 4)
                opcode = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
            else if ((roll < 74) == filling)
                opcode = OP_PUSH_A + 3'($urandom_range(2));
            else
                opcode = OP_POP_A + 3'($urandom_range(2));
            send_item(opcode, pick_value(), pick_value());
        end
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 33;
        take_idle_pct = 63;
        test_empty_pops();
        test_extreme_values();
        test_unused_opcodes();
        test_fill_to_overflow();
        test_random_traffic(33, 63, 360);
        test_random_traffic(63, 33, 360);
        test_random_traffic(0, 0, 380);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (failures == 0)
            $display("** dual_stack_shared_store: PASSED **");
        else
            $display("** dual_stack_shared_store: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dss_pkg.sv
hw/rtl/dss_front.sv
hw/rtl/dss_back.sv
hw/rtl/dual_stack_shared_store.sv
dv/tb_top.sv
